### hdl/cst_pkg.sv
// Shared types, codes and character constants of the character stream tokenizer.
package cst_pkg;

	// Token kinds carried on the result channel
	typedef enum logic [1:0] {
		KIND_IDENT = 2'd0,
		KIND_INT   = 2'd1,
		KIND_DEC   = 2'd2,
		KIND_COMMA = 2'd3
	} kind_t;

	// Scanner mode
	typedef enum logic [1:0] {
		MODE_IDLE    = 2'd0,
		MODE_IDENT   = 2'd1,
		MODE_NUMBER  = 2'd2,
		MODE_COMMENT = 2'd3
	} mode_t;

	localparam int MAG_OUT_W = 32;
	localparam int FRAC_W    = 4;
	localparam int DOT_W     = 2;

	localparam logic [7:0] CH_COMMA   = 8'h2C;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_DOT     = 8'h2E;
	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_USCORE  = 8'h5F;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_LOW_A   = 8'h61;
	localparam logic [7:0] CH_LOW_Z   = 8'h7A;
	localparam logic [7:0] CH_UP_A    = 8'h41;
	localparam logic [7:0] CH_UP_Z    = 8'h5A;
	localparam logic [7:0] DIGIT_MASK = 8'h0F;

	localparam logic [DOT_W-1:0]  DOTS_ONE  = 2'd1;
	localparam logic [DOT_W-1:0]  DOTS_MANY = 2'd2;
	localparam logic [FRAC_W-1:0] FRAC_MAX  = 4'd15;

	// One result word
	typedef struct packed {
		kind_t                token_kind;
		logic [7:0]           ident_char;
		logic                 ident_end;
		logic                 negative;
		logic [MAG_OUT_W-1:0] magnitude;
		logic [FRAC_W-1:0]    fraction_digits;
		logic                 overflow;
		logic                 last_result;
	} res_t;

	function automatic res_t make_ident(logic [7:0] ch, logic fin);
		res_t r;
		r            = '0;
		r.token_kind = KIND_IDENT;
		r.ident_char = ch;
		r.ident_end  = fin;
		return r;
	endfunction

	function automatic res_t make_comma();
		res_t r;
		r            = '0;
		r.token_kind = KIND_COMMA;
		return r;
	endfunction

	function automatic res_t make_number(logic neg, logic [MAG_OUT_W-1:0] mag,
			logic [DOT_W-1:0] dots, logic [FRAC_W-1:0] frac, logic ovf);
		res_t r;
		r            = '0;
		r.negative   = neg;
		r.magnitude  = mag;
		r.overflow   = ovf;
		if (dots == '0) begin
			r.token_kind = KIND_INT;
		end else begin
			r.token_kind      = KIND_DEC;
			r.fraction_digits = frac;
		end
		return r;
	endfunction

endpackage

### hdl/cst_char_if.sv
// Input channel: one source byte per word.
interface cst_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;
	logic       end_of_input;

	modport source (output valid, output char_in, output end_of_input, input ready);
	modport sink (input valid, input char_in, input end_of_input, output ready);
endinterface

### hdl/cst_token_if.sv
// Result channel: one token word per handshake.
interface cst_token_if;
	import cst_pkg::*;
	logic                 valid;
	logic                 ready;
	kind_t                token_kind;
	logic [7:0]           ident_char;
	logic                 ident_end;
	logic                 negative;
	logic [MAG_OUT_W-1:0] magnitude;
	logic [FRAC_W-1:0]    fraction_digits;
	logic                 overflow;
	logic                 last_result;

	modport source (output valid, output token_kind, output ident_char, output ident_end,
		output negative, output magnitude, output fraction_digits, output overflow,
		output last_result, input ready);
	modport sink (input valid, input token_kind, input ident_char, input ident_end,
		input negative, input magnitude, input fraction_digits, input overflow,
		input last_result, output ready);
endinterface

### hdl/char_stream_tokenizer_core.sv
// Character stream tokenizer: scanner state, number accumulator and result queue.
// A byte's result words enter the registered result queue when the byte is accepted.
// Throughput: one byte per cycle while the four-entry result queue has two free slots,
// and a byte can give up to two result words.
// Reset (arst_n low, asynchronous): scanner returns to idle, queue empties.
module char_stream_tokenizer_core #(
	parameter int MAGNITUDE_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	cst_char_if.sink             chars,
	cst_token_if.source          tokens
);
	import cst_pkg::*;

	localparam int WIDE_W = MAGNITUDE_BITS + 4;
	localparam int QDEPTH = 4;
	localparam int QIDX_W = 2;

	// Scanner state
	mode_t                     mode_q;
	logic                      slash_q;
	logic [7:0]                held_q;
	logic                      neg_q;
	logic                      first_q;
	logic [MAGNITUDE_BITS-1:0] acc_q;
	logic [DOT_W-1:0]          dots_q;
	logic [FRAC_W-1:0]         frac_q;
	logic                      ovf_q;

	// Result queue
	res_t                      ent_q [QDEPTH];
	res_t                      ent_n [QDEPTH];
	logic [QIDX_W:0]           cnt_q;
	logic [QIDX_W:0]           cnt_n;
	logic [QIDX_W:0]           base;

	logic       accept;
	logic       pop;
	logic [7:0] c;
	logic       eoi;
	logic       is_id, is_dig, is_num, is_comma, is_slash, is_nl;
	logic       start_b;
	logic       feed_en;
	logic       init;

	mode_t      mode_step;
	logic       slash_n;
	logic [7:0] held_n;

	// Number values before and after this byte
	logic                      b_neg, b_first, b_ovf;
	logic [MAGNITUDE_BITS-1:0] b_acc;
	logic [DOT_W-1:0]          b_dots;
	logic [FRAC_W-1:0]         b_frac;
	logic                      f_neg, f_ovf;
	logic [MAGNITUDE_BITS-1:0] f_acc;
	logic [DOT_W-1:0]          f_dots;
	logic [FRAC_W-1:0]         f_frac;
	logic [WIDE_W-1:0]         wide;
	logic [MAGNITUDE_BITS+MAG_OUT_W-1:0] ext_cur;
	logic [MAGNITUDE_BITS+MAG_OUT_W-1:0] ext_fed;

	res_t       rs [2];
	logic [1:0] n_res;

	assign accept = chars.valid && chars.ready;
	assign pop    = tokens.valid && tokens.ready;
	assign c      = chars.char_in;
	assign eoi    = chars.end_of_input;

	// Classify the byte
	assign is_id    = c inside {[CH_LOW_A:CH_LOW_Z], [CH_UP_A:CH_UP_Z], CH_USCORE};
	assign is_dig   = c inside {[CH_ZERO:CH_NINE]};
	assign is_num   = is_dig || c == CH_DOT || c == CH_MINUS;
	assign is_comma = c == CH_COMMA;
	assign is_slash = c == CH_SLASH;
	assign is_nl    = c == CH_NEWLINE;

	// Decide whether the byte opens a fresh token
	always_comb begin
		start_b = 1'b0;
		if (mode_q == MODE_COMMENT) begin
			start_b = 1'b0;
		end else if (slash_q) begin
			start_b = !is_slash;
		end else if (mode_q == MODE_IDENT) begin
			start_b = !is_id;
		end else if (mode_q == MODE_NUMBER) begin
			start_b = !is_num;
		end else begin
			start_b = 1'b1;
		end
	end

	assign init    = start_b && is_num;
	assign feed_en = init || (mode_q == MODE_NUMBER && !slash_q && is_num);

	// Next mode, slash flag and held character
	always_comb begin
		mode_step = mode_q;
		slash_n   = slash_q;
		held_n    = held_q;
		if (mode_q == MODE_COMMENT) begin
			if (is_nl) mode_step = MODE_IDLE;
		end else if (slash_q) begin
			slash_n = 1'b0;
			if (is_slash) mode_step = MODE_COMMENT;
		end else if (mode_q == MODE_IDENT) begin
			if (is_id) held_n = c;
		end
		if (start_b) begin
			mode_step = MODE_IDLE;
			if (is_id) begin
				mode_step = MODE_IDENT;
				held_n    = c;
			end else if (is_num) begin
				mode_step = MODE_NUMBER;
			end else if (is_slash) begin
				slash_n = 1'b1;
			end
		end
	end

	// Pick the number state to extend: fresh on a new number
	assign b_neg   = init ? 1'b0 : neg_q;
	assign b_first = init ? 1'b1 : first_q;
	assign b_acc   = init ? '0 : acc_q;
	assign b_dots  = init ? '0 : dots_q;
	assign b_frac  = init ? '0 : frac_q;
	assign b_ovf   = init ? 1'b0 : ovf_q;

	// Multiply by ten and add the digit
	assign wide = ({4'b0, b_acc} << 3) + ({4'b0, b_acc} << 1)
		+ WIDE_W'(c & DIGIT_MASK);

	// Fold the byte into the number
	always_comb begin
		f_neg  = b_neg | (b_first && c == CH_MINUS);
		f_acc  = b_acc;
		f_dots = b_dots;
		f_frac = b_frac;
		f_ovf  = b_ovf;
		if (c == CH_DOT) begin
			if (b_dots != DOTS_MANY) f_dots = b_dots + DOTS_ONE;
		end else if (is_dig) begin
			if (|wide[WIDE_W-1:MAGNITUDE_BITS]) begin
				f_acc = '1;
				f_ovf = 1'b1;
			end else begin
				f_acc = wide[MAGNITUDE_BITS-1:0];
			end
			if (b_dots != '0) begin
				if (b_frac != FRAC_MAX) f_frac = b_frac + 1'b1;
				else f_ovf = 1'b1;
			end
		end
	end

	assign ext_cur = {{MAG_OUT_W{1'b0}}, acc_q};
	assign ext_fed = {{MAG_OUT_W{1'b0}}, f_acc};

	// Build up to two result words for this byte
	always_comb begin
		rs[0] = '0;
		rs[1] = '0;
		n_res = 2'd0;
		if (mode_q != MODE_COMMENT && !slash_q) begin
			if (mode_q == MODE_IDENT) begin
				rs[n_res[0]] = make_ident(held_q, !is_id);
				n_res        = n_res + 2'd1;
			end else if (mode_q == MODE_NUMBER && !is_num && dots_q != DOTS_MANY) begin
				rs[n_res[0]] = make_number(neg_q, ext_cur[MAG_OUT_W-1:0], dots_q,
					frac_q, ovf_q);
				n_res        = n_res + 2'd1;
			end
		end
		if (start_b && is_comma) begin
			rs[n_res[0]] = make_comma();
			n_res        = n_res + 2'd1;
		end
		// Flush the pending token on the last byte
		if (eoi) begin
			if (mode_step == MODE_IDENT) begin
				rs[n_res[0]] = make_ident(held_n, 1'b1);
				n_res        = n_res + 2'd1;
			end else if (mode_step == MODE_NUMBER && f_dots != DOTS_MANY) begin
				rs[n_res[0]] = make_number(f_neg, ext_fed[MAG_OUT_W-1:0], f_dots,
					f_frac, f_ovf);
				n_res        = n_res + 2'd1;
			end
		end
		if (n_res == 2'd1) rs[0].last_result = 1'b1;
		if (n_res == 2'd2) rs[1].last_result = 1'b1;
	end

	// Advance scanner state; the last byte returns it to reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			slash_q <= 1'b0;
			held_q  <= '0;
			neg_q   <= 1'b0;
			first_q <= 1'b1;
			acc_q   <= '0;
			dots_q  <= '0;
			frac_q  <= '0;
			ovf_q   <= 1'b0;
		end else if (accept) begin
			if (eoi) begin
				mode_q  <= MODE_IDLE;
				slash_q <= 1'b0;
				held_q  <= '0;
				neg_q   <= 1'b0;
				first_q <= 1'b1;
				acc_q   <= '0;
				dots_q  <= '0;
				frac_q  <= '0;
				ovf_q   <= 1'b0;
			end else begin
				mode_q  <= mode_step;
				slash_q <= slash_n;
				held_q  <= held_n;
				if (feed_en) begin
					neg_q   <= f_neg;
					first_q <= 1'b0;
					acc_q   <= f_acc;
					dots_q  <= f_dots;
					frac_q  <= f_frac;
					ovf_q   <= f_ovf;
				end
			end
		end
	end

	// Shift out the head word, then append this byte's words
	always_comb begin
		for (int i = 0; i < QDEPTH; i++) ent_n[i] = ent_q[i];
		base = cnt_q;
		if (pop) begin
			for (int i = 0; i < QDEPTH - 1; i++) ent_n[i] = ent_q[i + 1];
			base = cnt_q - 1'b1;
		end
		cnt_n = base;
		if (accept) begin
			if (n_res != 2'd0) ent_n[base[QIDX_W-1:0]] = rs[0];
			if (n_res == 2'd2) ent_n[base[QIDX_W-1:0] + 1'b1] = rs[1];
			cnt_n = base + {1'b0, n_res};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_n;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < QDEPTH; i++) ent_q[i] <= ent_n[i];
	end

	// Take a byte only while two slots are free
	assign chars.ready = cnt_q < 3'(QDEPTH - 1);

	// Drive the head word
	assign tokens.valid           = cnt_q != '0;
	assign tokens.token_kind      = ent_q[0].token_kind;
	assign tokens.ident_char      = ent_q[0].ident_char;
	assign tokens.ident_end       = ent_q[0].ident_end;
	assign tokens.negative        = ent_q[0].negative;
	assign tokens.magnitude       = ent_q[0].magnitude;
	assign tokens.fraction_digits = ent_q[0].fraction_digits;
	assign tokens.overflow        = ent_q[0].overflow;
	assign tokens.last_result     = ent_q[0].last_result;

endmodule

### test/char_stream_tokenizer_core_checker.sv
// Token predictor and result checker for the character stream tokenizer.
module char_stream_tokenizer_core_checker
	import cst_pkg::*;
#(
	parameter int MAGNITUDE_BITS = 32
) (
	input  logic  clk,
	input  logic  arst_n,
	cst_char_if   chars,
	cst_token_if  tokens,
	output int    fails,
	output int    pending
);

	localparam logic [63:0] MAG_LIMIT = (MAGNITUDE_BITS >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF :
		((64'd1 << MAGNITUDE_BITS) - 64'd1);

	// Scanner copy
	mode_t             scan_mode;
	logic              slash_seen;
	logic [7:0]        held_char;
	logic              num_neg;
	logic              num_fresh;
	logic [63:0]       num_mag;
	logic [DOT_W-1:0]  num_dots;
	logic [FRAC_W-1:0] num_frac;
	logic              num_ovf;

	res_t step_words[$];
	res_t token_words_due[$];
	int   words_seen;

	initial begin
		fails   = 0;
		pending = 0;
		words_seen = 0;
	end

	function automatic bit is_alpha(logic [7:0] c);
		return (c >= CH_LOW_A && c <= CH_LOW_Z) || (c >= CH_UP_A && c <= CH_UP_Z) ||
			c == CH_USCORE;
	endfunction

	function automatic bit is_digit(logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	function automatic bit is_numeric(logic [7:0] c);
		return is_digit(c) || c == CH_DOT || c == CH_MINUS;
	endfunction

	function automatic void clear_scanner();
		scan_mode  = MODE_IDLE;
		slash_seen = 1'b0;
		held_char  = '0;
		num_neg    = 1'b0;
		num_fresh  = 1'b1;
		num_mag    = '0;
		num_dots   = '0;
		num_frac   = '0;
		num_ovf    = 1'b0;
	endfunction

	function automatic void push_ident(logic fin);
		res_t w;
		w            = '0;
		w.token_kind = KIND_IDENT;
		w.ident_char = held_char;
		w.ident_end  = fin;
		step_words.push_back(w);
	endfunction

	// Integer for no dot, decimal for one, nothing for more
	function automatic void push_number();
		res_t w;
		w           = '0;
		w.negative  = num_neg;
		w.magnitude = num_mag[MAG_OUT_W-1:0];
		w.overflow  = num_ovf;
		if (num_dots == '0) begin
			w.token_kind = KIND_INT;
			step_words.push_back(w);
		end else if (num_dots == DOTS_ONE) begin
			w.token_kind      = KIND_DEC;
			w.fraction_digits = num_frac;
			step_words.push_back(w);
		end
	endfunction

	// Fold one number byte into sign, magnitude and dot count
	function automatic void accumulate(logic [7:0] c);
		logic [63:0] d;
		if (num_fresh && c == CH_MINUS)
			num_neg = 1'b1;
		num_fresh = 1'b0;
		if (c == CH_DOT) begin
			if (num_dots < DOTS_MANY)
				num_dots = num_dots + 1'b1;
		end else if (is_digit(c)) begin
			d = 64'(c & DIGIT_MASK);
			if (num_mag > (MAG_LIMIT - d) / 64'd10) begin
				num_mag = MAG_LIMIT;
				num_ovf = 1'b1;
			end else begin
				num_mag = num_mag * 64'd10 + d;
			end
			if (num_dots >= DOTS_ONE) begin
				if (num_frac < FRAC_MAX)
					num_frac = num_frac + 1'b1;
				else
					num_ovf = 1'b1;
			end
		end
	endfunction

	// Start a token from idle
	function automatic void open_token(logic [7:0] c);
		if (is_alpha(c)) begin
			scan_mode = MODE_IDENT;
			held_char = c;
		end else if (is_numeric(c)) begin
			scan_mode = MODE_NUMBER;
			num_neg   = 1'b0;
			num_fresh = 1'b1;
			num_mag   = '0;
			num_dots  = '0;
			num_frac  = '0;
			num_ovf   = 1'b0;
			accumulate(c);
		end else if (c == CH_COMMA) begin
			res_t w;
			w            = '0;
			w.token_kind = KIND_COMMA;
			step_words.push_back(w);
		end else if (c == CH_SLASH) begin
			slash_seen = 1'b1;
		end
	endfunction

	// Work out the result words of one accepted byte and queue them
	function automatic void predict_byte(logic [7:0] c, logic eoi);
		res_t w;
		step_words.delete();
		if (scan_mode == MODE_COMMENT) begin
			if (c == CH_NEWLINE)
				scan_mode = MODE_IDLE;
		end else if (slash_seen) begin
			slash_seen = 1'b0;
			if (c == CH_SLASH)
				scan_mode = MODE_COMMENT;
			else
				open_token(c);
		end else if (scan_mode == MODE_IDENT) begin
			if (is_alpha(c)) begin
				push_ident(1'b0);
				held_char = c;
			end else begin
				push_ident(1'b1);
				scan_mode = MODE_IDLE;
				open_token(c);
			end
		end else if (scan_mode == MODE_NUMBER) begin
			if (is_numeric(c)) begin
				accumulate(c);
			end else begin
				push_number();
				scan_mode = MODE_IDLE;
				open_token(c);
			end
		end else begin
			scan_mode = MODE_IDLE;
			open_token(c);
		end
		// Flush the pending token on the last byte
		if (eoi) begin
			if (scan_mode == MODE_IDENT)
				push_ident(1'b1);
			else if (scan_mode == MODE_NUMBER)
				push_number();
			clear_scanner();
		end
		if (step_words.size() > 0) begin
			w = step_words.pop_back();
			w.last_result = 1'b1;
			step_words.push_back(w);
		end
		foreach (step_words[i])
			token_words_due.push_back(step_words[i]);
	endfunction

	task automatic report_mismatch(string msg);
		if (fails < 50)
			$display("[%0t] token mismatch: %s", $realtime, msg);
		fails = fails + 1;
	endtask

	task automatic check_field(string field, logic [63:0] got, logic [63:0] want);
		if (got !== want)
			report_mismatch($sformatf("word %0d %s got %0h expected %0h",
				words_seen, field, got, want));
	endtask

	// Predict on each accepted byte, compare each accepted word
	always @(posedge clk) begin
		res_t want;
		if (!arst_n) begin
			clear_scanner();
			token_words_due.delete();
		end else begin
			if (chars.valid === 1'b1 && chars.ready === 1'b1)
				predict_byte(chars.char_in, chars.end_of_input);
			if (tokens.valid === 1'b1 && tokens.ready === 1'b1) begin
				if (token_words_due.size() == 0) begin
					report_mismatch($sformatf("word %0d arrived with none due", words_seen));
				end else begin
					want = token_words_due.pop_front();
					check_field("token_kind", 64'(tokens.token_kind), 64'(want.token_kind));
					check_field("ident_char", 64'(tokens.ident_char), 64'(want.ident_char));
					check_field("ident_end", 64'(tokens.ident_end), 64'(want.ident_end));
					check_field("negative", 64'(tokens.negative), 64'(want.negative));
					check_field("magnitude", 64'(tokens.magnitude), 64'(want.magnitude));
					check_field("fraction_digits", 64'(tokens.fraction_digits),
						64'(want.fraction_digits));
					check_field("overflow", 64'(tokens.overflow), 64'(want.overflow));
					check_field("last_result", 64'(tokens.last_result), 64'(want.last_result));
				end
				words_seen = words_seen + 1;
			end
		end
		pending = token_words_due.size();
	end

endmodule

### test/char_stream_tokenizer_core_tb.sv
// Stimulus, handshake pacing and verdict for the character stream tokenizer.
module char_stream_tokenizer_core_tb;
	import cst_pkg::*;

	localparam int ITEM_TARGET = 1400;
	localparam int CALM_FROM   = 1150;

	// Opening stream: identifiers, numbers, dots, slashes, comments, flushes
	localparam logic [7:0] OPENING [25] = '{
		"a", "_", "Z", CH_COMMA,
		CH_MINUS, "7", CH_DOT, "5", 8'hFF,
		"1", CH_DOT, CH_DOT, "2", 8'h00,
		CH_MINUS, CH_SLASH, "x",
		CH_SLASH, CH_SLASH, "q", CH_NEWLINE,
		"9",
		CH_SLASH, CH_SLASH,
		CH_DOT
	};

	logic clk = 1'b0;
	logic arst_n;
	int   fails;
	int   pending;
	int   fed;
	bit   calm;
	bit   bursty;
	logic [7:0] frag[$];

	cst_char_if  chars();
	cst_token_if tokens();

	char_stream_tokenizer_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars),
		.tokens (tokens)
	);

	char_stream_tokenizer_core_checker watch (
		.clk     (clk),
		.arst_n  (arst_n),
		.chars   (chars),
		.tokens  (tokens),
		.fails   (fails),
		.pending (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Give up long after the slowest correct run
	initial begin
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

	function automatic logic [7:0] pick_alpha();
		case ($urandom_range(0, 2))
			0:       return CH_LOW_A + 8'($urandom_range(0, 25));
			1:       return CH_UP_A + 8'($urandom_range(0, 25));
			default: return CH_USCORE;
		endcase
	endfunction

	function automatic logic [7:0] pick_digit();
		return CH_ZERO + 8'($urandom_range(0, 9));
	endfunction

	// Offer one byte, maybe after a gap, and hold it until taken
	task automatic send_byte(logic [7:0] c, logic eoi);
		if (!calm && bursty && $urandom_range(0, 5) == 0) begin
			chars.valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		chars.valid        <= 1'b1;
		chars.char_in      <= c;
		chars.end_of_input <= eoi;
		@(posedge clk);
		while (chars.ready !== 1'b1)
			@(posedge clk);
	endtask

	// Stall the result side in bursts, with quiet windows
	initial begin
		int window;
		bit stalling;
		tokens.ready <= 1'b0;
		window   = 0;
		stalling = 1'b1;
		@(posedge clk);
		while (arst_n !== 1'b1)
			@(posedge clk);
		forever begin
			if (window == 0) begin
				stalling = $urandom_range(0, 2) != 0;
				window   = 64;
			end
			window = window - 1;
			if (!calm && stalling && $urandom_range(0, 7) == 0) begin
				tokens.ready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end
			tokens.ready <= 1'b1;
			@(posedge clk);
		end
	end

	initial begin
		int n;
		arst_n             <= 1'b0;
		chars.valid        <= 1'b0;
		chars.char_in      <= '0;
		chars.end_of_input <= 1'b0;
		calm   = 1'b0;
		bursty = 1'b1;
		fed    = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the opening stream; flush after the lone nine, the comment and the dot
		foreach (OPENING[i])
			send_byte(OPENING[i], i == 21 || i == 23 || i == 24);

		// Hold off until every word of the opening stream is out
		chars.valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		@(posedge clk);

		// Random source text built from token-shaped fragments
		while (fed < ITEM_TARGET) begin
			calm    = fed >= CALM_FROM;
			bursty  = $urandom_range(0, 2) != 0;
			frag.delete();
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					n = $urandom_range(1, 8);
					repeat (n) frag.push_back(pick_alpha());
				end
				3, 4, 5: begin
					if ($urandom_range(0, 3) == 0)
						frag.push_back(CH_MINUS);
					n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 22) : $urandom_range(0, 6);
					repeat (n) frag.push_back(pick_digit());
					case ($urandom_range(0, 6))
						0, 1: begin
							frag.push_back(CH_DOT);
							n = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 18) :
								$urandom_range(0, 5);
							repeat (n) frag.push_back(pick_digit());
						end
						2: begin
							frag.push_back(CH_DOT);
							frag.push_back(pick_digit());
							frag.push_back(CH_DOT);
							frag.push_back(pick_digit());
						end
						3: begin
							frag.push_back(CH_MINUS);
							frag.push_back(pick_digit());
						end
						default: ;
					endcase
				end
				6: frag.push_back(CH_COMMA);
				7: begin
					case ($urandom_range(0, 3))
						0:       frag.push_back(8'h20);
						1:       frag.push_back(CH_NEWLINE);
						2:       frag.push_back(CH_SLASH);
						default: frag.push_back(8'($urandom_range(0, 255)));
					endcase
				end
				8: begin
					// Comment of high bytes, usually closed by a newline
					frag.push_back(CH_SLASH);
					frag.push_back(CH_SLASH);
					n = $urandom_range(0, 6);
					repeat (n) frag.push_back(8'($urandom_range(0, 255)) | 8'h80);
					if ($urandom_range(0, 5) != 0)
						frag.push_back(CH_NEWLINE);
				end
				default: begin
					n = $urandom_range(1, 4);
					repeat (n) frag.push_back(8'($urandom_range(0, 255)));
				end
			endcase
			foreach (frag[i])
				send_byte(frag[i], $urandom_range(0, 49) == 0);
			fed = fed + frag.size();
		end

		// Drain and let any stray word show up
		chars.valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (16) @(posedge clk);
		if (fails == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
